// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvt assertion failed");

// next-cycle implication, disabled during reset
`define HVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvt assertion failed");

`endif

// File: hw/rtl/hvt_pkg.sv
// types, codes and constants of the versioned handle id table
`timescale 1ns / 1ps

package hvt_pkg;

  localparam int IdxW       = 10;
  localparam int VerInW     = 12;
  localparam int IdOutW     = 32;
  localparam int CapW       = 11;
  localparam int StatusW    = 3;
  localparam int ApbAddrW   = 3;
  localparam int ApbDataW   = 32;

  localparam int MaxSlotsDef    = 1024;
  localparam int VersionBitsDef = 12;
  localparam int IdBitsDef      = 32;

  typedef enum logic [1:0] {
    OpAssign  = 2'd0,
    OpGet     = 2'd1,
    OpDestroy = 2'd2,
    OpClear   = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StOk           = 3'd0,
    StDisabled     = 3'd1,
    StNotPrewarmed = 3'd2,
    StRange        = 3'd3,
    StExhausted    = 3'd4
  } status_e;

  typedef enum logic {
    RegEnable   = 1'b0,
    RegCapacity = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic            enabled;
    logic [CapW-1:0] capacity;
  } cfg_t;

endpackage

// File: hw/rtl/hvt_regs.sv
// apb configuration registers of the handle id table
`timescale 1ns / 1ps

module hvt_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hvt_pkg::ApbAddrW-1:0] paddr,
  input  logic [hvt_pkg::ApbDataW-1:0] pwdata,
  output logic [hvt_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output hvt_pkg::cfg_t                cfg_o
);

  hvt_pkg::cfg_t      cfg_q, cfg_d;
  hvt_pkg::reg_idx_e  reg_sel;
  logic               wr_en;

  assign reg_sel = hvt_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        hvt_pkg::RegEnable:   cfg_d.enabled  = pwdata[0];
        hvt_pkg::RegCapacity: cfg_d.capacity = pwdata[hvt_pkg::CapW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      hvt_pkg::RegEnable:   prdata[0] = cfg_q.enabled;
      hvt_pkg::RegCapacity: prdata[hvt_pkg::CapW-1:0] = cfg_q.capacity;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/versioned_handle_id_table_top.sv
// versioned handle id table: entry memory, lookup/update stage and id counter
`timescale 1ns / 1ps

// results are registered behind the input stage; one item per cycle while busy is low
// throughput is set by the single read-modify-write of the entry memory, with forwarding
// a clear holds busy in its input stage and, if enabled, through a clearing pass
// reset also starts the clearing pass over every slot; busy is high throughout
// config writes are taken at any time; results cannot be stalled by the receiver

module versioned_handle_id_table_top #(
  parameter int MAX_SLOTS    = hvt_pkg::MaxSlotsDef,
  parameter int VERSION_BITS = hvt_pkg::VersionBitsDef,
  parameter int ID_BITS      = hvt_pkg::IdBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hvt_pkg::ApbAddrW-1:0] paddr,
  input  logic [hvt_pkg::ApbDataW-1:0] pwdata,
  output logic [hvt_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [hvt_pkg::IdxW-1:0]     slot_index_i,
  input  logic [hvt_pkg::VerInW-1:0]   slot_version_i,
  output logic                         done_o,
  output logic [hvt_pkg::IdOutW-1:0]   stable_id_o,
  output logic                         found_o,
  output logic                         newly_assigned_o,
  output logic [hvt_pkg::StatusW-1:0]  status_o
);

  localparam int AddrW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int IdxExtW = (AddrW > hvt_pkg::IdxW) ? AddrW : hvt_pkg::IdxW;
  localparam int VerExtW = (VERSION_BITS > hvt_pkg::VerInW) ? VERSION_BITS : hvt_pkg::VerInW;
  localparam int IdExtW  = (ID_BITS > hvt_pkg::IdOutW) ? ID_BITS : hvt_pkg::IdOutW;
  localparam int CapSatW = $clog2(MAX_SLOTS + 1);
  localparam int CapExtW = (CapSatW > hvt_pkg::CapW) ? CapSatW : hvt_pkg::CapW;
  localparam int EntW    = 1 + VERSION_BITS + ID_BITS;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_SLOTS - 1);

  hvt_pkg::cfg_t cfg;

  hvt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // entry: {valid, version, id}
  logic [EntW-1:0] mem_q [MAX_SLOTS];
  logic [EntW-1:0] rd_q;

  logic                    accept;
  logic [IdxExtW-1:0]      in_idx_ext;
  logic [VerExtW-1:0]      in_ver_ext;
  logic [AddrW-1:0]        in_addr;

  logic                    s1_vld_q;
  hvt_pkg::opcode_e        s1_op_q;
  logic [hvt_pkg::IdxW-1:0] s1_idx_q;
  logic [AddrW-1:0]        s1_addr_q;
  logic [VERSION_BITS-1:0] s1_ver_q;

  logic                    fwd_vld_q;
  logic [AddrW-1:0]        fwd_addr_q;
  logic [EntW-1:0]         fwd_ent_q;

  logic                    sweep_q;
  logic [AddrW-1:0]        sweep_cnt_q;
  logic                    sweep_start;

  logic [ID_BITS-1:0]      next_id_q, next_id_d;

  logic [EntW-1:0]         ent;
  logic                    ent_valid;
  logic [VERSION_BITS-1:0] ent_ver;
  logic [ID_BITS-1:0]      ent_id;
  logic                    match;
  logic [CapExtW-1:0]      cap_ext, cap_eff;
  logic                    cap_zero, out_of_range;

  logic                    wr_en;
  logic [EntW-1:0]         wr_ent;
  logic [ID_BITS-1:0]      res_id;
  logic                    res_found, res_new;
  hvt_pkg::status_e        res_status;
  logic [IdExtW-1:0]       res_id_ext;

  logic                           done_q;
  logic [hvt_pkg::IdOutW-1:0]     stable_id_q;
  logic                           found_q, newly_q;
  hvt_pkg::status_e               status_q;

  assign busy       = sweep_q | (s1_vld_q & (s1_op_q == hvt_pkg::OpClear));
  assign accept     = start & ~busy;
  assign in_idx_ext = IdxExtW'(slot_index_i);
  assign in_ver_ext = VerExtW'(slot_version_i);
  assign in_addr    = in_idx_ext[AddrW-1:0];

  // input stage and memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= hvt_pkg::opcode_e'(opcode_i);
      s1_idx_q  <= slot_index_i;
      s1_addr_q <= in_addr;
      s1_ver_q  <= in_ver_ext[VERSION_BITS-1:0];
      rd_q      <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem_q[sweep_cnt_q] <= '0;
    end else if (wr_en) begin
      mem_q[s1_addr_q] <= wr_ent;
    end
  end

  // forward the last write to a read issued at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_ent_q  <= wr_ent;
    end
  end

  assign ent       = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_ent_q : rd_q;
  assign ent_valid = ent[EntW-1];
  assign ent_ver   = ent[ID_BITS +: VERSION_BITS];
  assign ent_id    = ent[ID_BITS-1:0];
  assign match     = ent_valid && (ent_ver == s1_ver_q);

  assign cap_ext      = CapExtW'(cfg.capacity);
  assign cap_eff      = (cap_ext > CapExtW'(MAX_SLOTS)) ? CapExtW'(MAX_SLOTS) : cap_ext;
  assign cap_zero     = (cap_eff == '0);
  assign out_of_range = (CapExtW'(s1_idx_q) >= cap_eff);

  // lookup and update
  always_comb begin
    wr_en       = 1'b0;
    wr_ent      = ent;
    res_id      = '0;
    res_found   = 1'b0;
    res_new     = 1'b0;
    res_status  = hvt_pkg::StOk;
    next_id_d   = next_id_q;
    sweep_start = 1'b0;
    if (s1_vld_q) begin
      if (!cfg.enabled) begin
        res_status = hvt_pkg::StDisabled;
      end else if (s1_op_q == hvt_pkg::OpClear) begin
        sweep_start = 1'b1;
        next_id_d   = ID_BITS'(1);
      end else if (cap_zero) begin
        res_status = hvt_pkg::StNotPrewarmed;
      end else if (out_of_range) begin
        res_status = hvt_pkg::StRange;
      end else begin
        case (s1_op_q)
          hvt_pkg::OpAssign: begin
            if (match) begin
              res_id    = ent_id;
              res_found = 1'b1;
            end else if (next_id_q == '0) begin
              res_status = hvt_pkg::StExhausted;
            end else begin
              res_id    = next_id_q;
              res_found = 1'b1;
              res_new   = 1'b1;
              wr_en     = 1'b1;
              wr_ent    = {1'b1, s1_ver_q, next_id_q};
              next_id_d = next_id_q + ID_BITS'(1);
            end
          end
          hvt_pkg::OpGet: begin
            if (match) begin
              res_id    = ent_id;
              res_found = 1'b1;
            end
          end
          hvt_pkg::OpDestroy: begin
            if (match) begin
              wr_en  = 1'b1;
              wr_ent = {1'b0, ent_ver, ent_id};
            end
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end
    end
  end

  assign res_id_ext = IdExtW'(res_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q   <= ID_BITS'(1);
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      done_q      <= 1'b0;
    end else begin
      next_id_q <= next_id_d;
      done_q    <= s1_vld_q;
      if (sweep_start) begin
        sweep_q     <= 1'b1;
        sweep_cnt_q <= '0;
      end else if (sweep_q) begin
        if (sweep_cnt_q == LastAddr) begin
          sweep_q <= 1'b0;
        end else begin
          sweep_cnt_q <= sweep_cnt_q + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      stable_id_q <= res_id_ext[hvt_pkg::IdOutW-1:0];
      found_q     <= res_found;
      newly_q     <= res_new;
      status_q    <= res_status;
    end
  end

  assign done_o           = done_q;
  assign stable_id_o      = stable_id_q;
  assign found_o          = found_q;
  assign newly_assigned_o = newly_q;
  assign status_o         = status_q;

endmodule

// File: hw/rtl/hvt_checker.sv
// port-level checker of the handle id table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hvt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [hvt_pkg::IdOutW-1:0]  stable_id_o,
  input logic                        found_o,
  input logic                        newly_assigned_o,
  input logic [hvt_pkg::StatusW-1:0] status_o
);

  `HVT_ASSERT_NXT(a_beat_latency, clk_i, rst_ni, start && !busy, ##1 done_o)
  `HVT_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, done_o, $past(start && !busy, 2))
  `HVT_ASSERT_IMP(a_found_ok, clk_i, rst_ni, done_o && found_o, status_o == hvt_pkg::StOk)
  `HVT_ASSERT_IMP(a_new_found, clk_i, rst_ni, done_o && newly_assigned_o, found_o && (stable_id_o != '0))
  `HVT_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_o && !found_o, (stable_id_o == '0) && !newly_assigned_o)

endmodule

bind versioned_handle_id_table_top hvt_checker u_hvt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .stable_id_o      (stable_id_o),
  .found_o          (found_o),
  .newly_assigned_o (newly_assigned_o),
  .status_o         (status_o)
);

// File: tb/versioned_handle_id_table_top_tb.sv
// self-checking testbench for the versioned handle id table: directed table, then random handles
`timescale 1ns / 1ps

module versioned_handle_id_table_top_tb;
  import hvt_pkg::*;

  localparam int StallLimit = 6000;
  localparam int ItemTarget = 1550;

  typedef struct packed {
    logic [IdOutW-1:0] id;
    logic              found;
    logic              fresh;
    status_e           status;
  } table_result_t;

  typedef enum logic {
    RowItem,
    RowWrite
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    opcode_e           op;
    logic [IdxW-1:0]   idx;
    logic [VerInW-1:0] ver;
    logic              typed;
    table_result_t     want;
    reg_idx_e          reg_sel;
    logic [31:0]       wdata;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          opcode_i = '0;
  logic [IdxW-1:0]     slot_index_i = '0;
  logic [VerInW-1:0]   slot_version_i = '0;
  logic                done_o;
  logic [IdOutW-1:0]   stable_id_o;
  logic                found_o;
  logic                newly_assigned_o;
  logic [StatusW-1:0]  status_o;

  versioned_handle_id_table_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .slot_index_i     (slot_index_i),
    .slot_version_i   (slot_version_i),
    .done_o           (done_o),
    .stable_id_o      (stable_id_o),
    .found_o          (found_o),
    .newly_assigned_o (newly_assigned_o),
    .status_o         (status_o)
  );

  // shadow of the entry memory, id counter and registers
  logic [MaxSlotsDef-1:0] tab_valid = '0;
  logic [IdOutW-1:0]      tab_id [MaxSlotsDef];
  logic [VerInW-1:0]      tab_ver [MaxSlotsDef];
  logic [IdOutW-1:0]      id_counter = 1;
  logic                   cfg_enabled = 1'b0;
  logic [CapW-1:0]        cfg_capacity = '0;

  table_result_t     pending_results [$];
  int                mismatches = 0;
  int                items_done = 0;
  int                stall_cycles = 0;
  logic [IdxW-1:0]   pool_idx [8];
  logic [VerInW-1:0] pool_ver [8];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic table_result_t apply_table_op(opcode_e op, logic [IdxW-1:0] idx,
                                                   logic [VerInW-1:0] ver);
    table_result_t r;
    int            cap;
    logic          hit;
    r = '{id: '0, found: 1'b0, fresh: 1'b0, status: StOk};
    cap = (int'(cfg_capacity) > MaxSlotsDef) ? MaxSlotsDef : int'(cfg_capacity);
    if (!cfg_enabled) begin
      r.status = StDisabled;
    end else if (op == OpClear) begin
      tab_valid = '0;
      id_counter = 1;
    end else if (cap == 0) begin
      r.status = StNotPrewarmed;
    end else if (int'(idx) >= cap) begin
      r.status = StRange;
    end else begin
      hit = tab_valid[idx] && (tab_ver[idx] == ver);
      case (op)
        OpAssign: begin
          if (hit) begin
            r.id = tab_id[idx];
            r.found = 1'b1;
          end else if (id_counter == 0) begin
            r.status = StExhausted;
          end else begin
            r.id = id_counter;
            r.found = 1'b1;
            r.fresh = 1'b1;
            tab_valid[idx] = 1'b1;
            tab_id[idx] = id_counter;
            tab_ver[idx] = ver;
            id_counter = id_counter + 1;
          end
        end
        OpGet: begin
          if (hit) begin
            r.id = tab_id[idx];
            r.found = 1'b1;
          end
        end
        default: begin
          if (hit) tab_valid[idx] = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  function automatic row_t item_row(opcode_e op, logic [IdxW-1:0] idx, logic [VerInW-1:0] ver);
    row_t r;
    r.kind = RowItem;
    r.op = op;
    r.idx = idx;
    r.ver = ver;
    r.typed = 1'b0;
    r.want = '{id: '0, found: 1'b0, fresh: 1'b0, status: StOk};
    r.reg_sel = RegEnable;
    r.wdata = '0;
    return r;
  endfunction

  function automatic row_t item_typed(opcode_e op, logic [IdxW-1:0] idx,
                                      logic [VerInW-1:0] ver, logic [IdOutW-1:0] id,
                                      logic found, logic fresh, status_e st);
    row_t r;
    r = item_row(op, idx, ver);
    r.typed = 1'b1;
    r.want = '{id: id, found: found, fresh: fresh, status: st};
    return r;
  endfunction

  function automatic row_t write_row(reg_idx_e sel, logic [31:0] value);
    row_t r;
    r = item_row(OpGet, '0, '0);
    r.kind = RowWrite;
    r.reg_sel = sel;
    r.wdata = value;
    return r;
  endfunction

  task automatic reg_write(input reg_idx_e sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == RegEnable) cfg_enabled = value[0];
    else cfg_capacity = value[CapW-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input opcode_e op, input logic [IdxW-1:0] idx,
                           input logic [VerInW-1:0] ver, input logic typed,
                           input table_result_t want);
    table_result_t r;
    start <= 1'b1;
    opcode_i <= op;
    slot_index_i <= idx;
    slot_version_i <= ver;
    do @(posedge clk_i); while (busy);
    r = apply_table_op(op, idx, ver);
    pending_results.push_back(typed ? want : r);
    if (r.status != StDisabled && r.status != StNotPrewarmed) items_done++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy);
    repeat (2) @(posedge clk_i);
  endtask

  // mostly handles from a small pool, some stale versions, some raw noise
  task automatic pick_item(output opcode_e op, output logic [IdxW-1:0] idx,
                           output logic [VerInW-1:0] ver);
    logic [2:0] k;
    int roll;
    int span;
    int pick;
    k = 3'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    span = (cfg_capacity == 0 || cfg_capacity > MaxSlotsDef) ? MaxSlotsDef : cfg_capacity;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 3) == 0) pool_idx[k] = IdxW'($urandom_range(0, span - 1));
      else pool_idx[k] = IdxW'($urandom_range(0, (span > 32 ? 32 : span) - 1));
      pool_ver[k] = VerInW'($urandom);
    end else if ($urandom_range(0, 11) == 0) begin
      pool_ver[k] = pool_ver[k] + 1'b1;
    end
    if (roll < 10) begin
      op = ($urandom_range(0, 19) == 0) ? OpClear : opcode_e'($urandom_range(0, 2));
      idx = IdxW'($urandom);
      ver = VerInW'($urandom);
    end else begin
      idx = pool_idx[k];
      ver = pool_ver[k];
      if (roll < 16) ver = ver ^ (VerInW'(1) << $urandom_range(0, VerInW - 1));
      pick = $urandom_range(0, 199);
      if (pick < 2) op = OpClear;
      else if (pick < 80) op = OpAssign;
      else if (pick < 150) op = OpGet;
      else op = OpDestroy;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (stable_id_o !== want.id) begin
          $error("stable_id: expected %0h, got %0h", want.id, stable_id_o);
          mismatches++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found_o);
          mismatches++;
        end
        if (newly_assigned_o !== want.fresh) begin
          $error("newly_assigned: expected %0b, got %0b", want.fresh, newly_assigned_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("versioned_handle_id_table_top_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t            plan [$];
    table_result_t   no_want;
    opcode_e         op;
    logic [IdxW-1:0] idx;
    logic [VerInW-1:0] ver;
    int              idle_pct;
    int              burst;
    logic            en;
    logic [CapW-1:0] cap;

    no_want = '{id: '0, found: 1'b0, fresh: 1'b0, status: StOk};
    for (int i = 0; i < 8; i++) begin
      pool_idx[3'(i)] = IdxW'(i);
      pool_ver[3'(i)] = VerInW'($urandom);
    end
    plan = '{
      item_typed(OpAssign, 0, 0, 0, 1'b0, 1'b0, StDisabled),
      item_typed(OpClear, 0, 0, 0, 1'b0, 1'b0, StDisabled),
      write_row(RegEnable, 1),
      item_typed(OpAssign, 1023, 4095, 0, 1'b0, 1'b0, StNotPrewarmed),
      item_typed(OpGet, 512, 2048, 0, 1'b0, 1'b0, StNotPrewarmed),
      item_typed(OpClear, 0, 0, 0, 1'b0, 1'b0, StOk),
      write_row(RegCapacity, 2047),
      item_typed(OpAssign, 1023, 4095, 1, 1'b1, 1'b1, StOk),
      item_row(OpGet, 1023, 4095),
      item_row(OpGet, 1023, 0),
      item_row(OpAssign, 0, 0),
      item_row(OpAssign, 1023, 4095),
      item_row(OpDestroy, 1023, 4094),
      item_row(OpDestroy, 1023, 4095),
      item_row(OpGet, 1023, 4095),
      item_row(OpAssign, 1023, 4094),
      write_row(RegCapacity, 1),
      item_typed(OpGet, 1, 4094, 0, 1'b0, 1'b0, StRange),
      item_typed(OpDestroy, 1023, 4094, 0, 1'b0, 1'b0, StRange),
      item_row(OpGet, 0, 0),
      write_row(RegCapacity, 0),
      item_typed(OpDestroy, 0, 0, 0, 1'b0, 1'b0, StNotPrewarmed),
      write_row(RegCapacity, 1024),
      item_row(OpGet, 1023, 4094),
      item_typed(OpClear, 0, 0, 0, 1'b0, 1'b0, StOk),
      item_row(OpGet, 1023, 4094),
      item_typed(OpAssign, 1023, 4094, 1, 1'b1, 1'b1, StOk),
      write_row(RegEnable, 0),
      item_typed(OpDestroy, 1023, 4094, 0, 1'b0, 1'b0, StDisabled)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        settle();
        reg_write(plan[i].reg_sel, plan[i].wdata);
      end else begin
        send_item(plan[i].op, plan[i].idx, plan[i].ver, plan[i].typed, plan[i].want);
      end
    end

    for (int sp = 0; items_done < ItemTarget; sp++) begin
      settle();
      en = 1'b1;
      case (sp % 7)
        0: cap = 16;
        1: cap = 1024;
        2: cap = CapW'($urandom_range(1, 2047));
        3: cap = 1;
        4: cap = 2047;
        5: begin
          en = 1'b0;
          cap = CapW'($urandom_range(0, 2047));
        end
        default: cap = 0;
      endcase
      reg_write(RegEnable, 32'(en));
      reg_write(RegCapacity, 32'(cap));
      if (items_done < ItemTarget / 3) idle_pct = 31;
      else if (items_done < 2 * ItemTarget / 3) idle_pct = 64;
      else idle_pct = 0;
      burst = (en && cap != 0) ? 130 : 20;
      repeat (burst) begin
        while ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
        pick_item(op, idx, ver);
        send_item(op, idx, ver, 1'b0, no_want);
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("versioned_handle_id_table_top_tb: done, clean");
    end else begin
      $display("versioned_handle_id_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule
